// File: hw/rtl/bfa_pkg.sv
package bfa_pkg;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int ARENA_MAX_BYTES_DEF = 16384;
  localparam int MAX_BLOCKS_DEF = 1024;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_BAD_SIZE = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;
endpackage

// File: hw/rtl/bfa_table.sv
module bfa_table #(
  parameter int DW = 64,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/best_fit_block_allocator.sv
// Best-fit block allocator over an address-ordered block list.
// An allocate walks the whole block list, then grants the best fit and splits it; a free
// walks the list up to the block it frees, then merges it with free neighbours. One word
// is worked on at a time; the walk over the block table, which has one read port and one
// write port, sets the rate, and the next word is taken once the result has been accepted.
// Reset (synchronous, active high) and each arena write run a format pass that refills
// the spare stack; no word is accepted during that pass.
module best_fit_block_allocator #(
  parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF,
  parameter int ARENA_MAX_BYTES = bfa_pkg::ARENA_MAX_BYTES_DEF,
  parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [14:0] request_size,
  input  logic [13:0] block_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [13:0] data_offset,
  output logic [14:0] granted_bytes
);
  import bfa_pkg::*;

  // Index width carries one extra bit so that MAX_BLOCKS itself can mark "no block".
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int IW = AW + 1;
  localparam int SW = 17;
  localparam int DW = SW + 2 * IW + 1;
  localparam logic [IW-1:0] NONE = IW'(MAX_BLOCKS);
  localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] AMAX = SW'(ARENA_MAX_BYTES);

  typedef struct packed {
    logic [SW-1:0] size;
    logic [IW-1:0] next;
    logic [IW-1:0] prev;
    logic          used;
  } blk_t;

  typedef enum logic [4:0] {
    S_FMT, S_FMT_SP, S_IDLE, S_RD, S_RDW, S_EXAM, S_PICK, S_SPLIT_POP, S_SPLIT_POPW,
    S_SPLIT_W, S_SPLIT_NRD, S_SPLIT_NRDW, S_SPLIT_NW, S_FR_RD, S_FR_RDW,
    S_FR_P, S_FR_PW, S_FR_N, S_FR_NW, S_FR_NN, S_FR_NNW, S_FR_SW, S_FR_SX, S_FR_CUR, S_OUT
  } state_t;

  state_t state;

  // Block table and spare stack memories.
  logic          t_we;
  logic [AW-1:0] t_waddr, t_raddr;
  blk_t          t_wdata;
  logic [DW-1:0] t_rraw;
  blk_t          t_r;

  bfa_table #(.DW(DW), .AW(AW)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rraw)
  );
  assign t_r = blk_t'(t_rraw);

  logic [AW-1:0] spare [MAX_BLOCKS];
  logic [AW-1:0] sp_rd;
  logic [IW-1:0] sp_cnt;

  logic [14:0]   arena;
  logic [IW-1:0] first, cur, pick, tight, roomy, tmp_n;
  logic [SW-1:0] pos, tight_pos, roomy_pos, tight_sz, roomy_sz, need, req, off;
  logic [IW-1:0] steps;
  logic [AW:0]   fmt_i;
  logic          op;
  blk_t          cb;
  logic [SW-1:0] eff;

  assign eff = (SW'(arena) > AMAX) ? AMAX : SW'(arena);
  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_ready = (state == S_IDLE) && !out_valid && !cfg_valid;

  always_ff @(posedge clk) begin
    if (state == S_SPLIT_POP) begin
      sp_rd <= spare[sp_cnt[AW-1:0] - AW'(1)];
    end
    if (state == S_FMT) begin
      spare[fmt_i[AW-1:0]] <= AW'(MAX_BLOCKS - 1) - fmt_i[AW-1:0];
    end else if ((state == S_FR_PW || state == S_FR_NNW) && sp_cnt < NONE) begin
      spare[sp_cnt[AW-1:0]] <= tmp_n[AW-1:0];
    end
  end

  // Table write strobe: registered, so it rises in the cycle after the state that sets up the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      t_we <= 1'b0;
    end else begin
      case (state)
        S_FMT_SP: t_we <= (eff > HDR);
        S_SPLIT_W, S_SPLIT_NRD, S_SPLIT_NW, S_FR_SX, S_FR_CUR: t_we <= 1'b1;
        S_FR_NN: t_we <= t_r.used && (t_r.prev != cur);
        default: t_we <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FMT;
      arena <= 15'd16384;
      fmt_i <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_FMT: begin
          // Spare stack holds MAX_BLOCKS-1 down to 1, top at index MAX_BLOCKS-2.
          fmt_i <= fmt_i + 1'b1;
          if (fmt_i == (AW+1)'(MAX_BLOCKS - 2)) state <= S_FMT_SP;
        end
        S_FMT_SP: begin
          if (eff > HDR) begin
            t_waddr <= '0;
            t_wdata <= '{size: eff - HDR, next: NONE, prev: NONE, used: 1'b0};
            first <= '0;
            sp_cnt <= IW'(MAX_BLOCKS - 1);
          end else begin
            first <= NONE;
            sp_cnt <= IW'(MAX_BLOCKS);
            tmp_n <= '0;
          end
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (out_valid && out_ready) out_valid <= 1'b0;
          if (cfg_valid && cfg_ready) begin
            arena <= cfg_data;
            fmt_i <= '0;
            state <= S_FMT;
          end else if (in_valid && in_ready) begin
            op <= opcode;
            req <= SW'(request_size);
            need <= SW'(request_size) + HDR;
            off <= SW'(block_offset);
            cur <= first;
            pos <= '0;
            steps <= '0;
            tight <= NONE;
            roomy <= NONE;
            data_offset <= '0;
            granted_bytes <= '0;
            if (opcode == OP_ALLOC && request_size == '0) begin
              status <= ST_BAD_SIZE;
              out_valid <= 1'b1;
            end else begin
              status <= ST_DONE;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (cur >= NONE || steps >= NONE) begin
            state <= (op == OP_FREE) ? S_OUT : S_PICK;
            if (op == OP_FREE) status <= ST_IGNORED;
          end else begin
            t_raddr <= cur[AW-1:0];
            state <= S_RDW;
          end
        end
        S_RDW: state <= S_EXAM;
        S_EXAM: begin
          cb <= t_r;
          if (op == OP_FREE && pos + HDR == off) begin
            if (t_r.used) begin
              state <= S_FR_P;
            end else begin
              status <= ST_IGNORED;
              state <= S_OUT;
            end
          end else begin
            if (op == OP_ALLOC && !t_r.used) begin
              if (t_r.size >= need && (roomy == NONE || t_r.size < roomy_sz)) begin
                roomy <= cur; roomy_pos <= pos; roomy_sz <= t_r.size;
              end
              if (t_r.size < need && t_r.size >= req &&
                  (tight == NONE || t_r.size < tight_sz)) begin
                tight <= cur; tight_pos <= pos; tight_sz <= t_r.size;
              end
            end
            pos <= pos + HDR + t_r.size;
            cur <= t_r.next;
            steps <= steps + 1'b1;
            state <= S_RD;
          end
        end
        S_PICK: begin
          if (tight != NONE) begin
            pick <= tight;
            data_offset <= 14'(tight_pos + HDR);
            granted_bytes <= 15'(tight_sz);
            t_raddr <= tight[AW-1:0];
            state <= S_SPLIT_POP;
          end else if (roomy != NONE) begin
            pick <= roomy;
            data_offset <= 14'(roomy_pos + HDR);
            granted_bytes <= 15'(roomy_sz);
            t_raddr <= roomy[AW-1:0];
            state <= S_SPLIT_POP;
          end else begin
            status <= ST_NO_FIT;
            state <= S_OUT;
          end
        end
        S_SPLIT_POP: begin
          // Spare word read in parallel with the table read; a tight fit is never split.
          if (tight == NONE && roomy_sz > need && sp_cnt != '0) begin
            sp_cnt <= sp_cnt - 1'b1;
            tmp_n <= '0;
          end else begin
            tmp_n <= NONE;
          end
          state <= S_SPLIT_POPW;
        end
        S_SPLIT_POPW: begin
          cb <= t_r;
          state <= S_SPLIT_W;
        end
        S_SPLIT_W: begin
          t_waddr <= pick[AW-1:0];
          if (tmp_n == NONE) begin
            t_wdata <= '{size: cb.size, next: cb.next, prev: cb.prev, used: 1'b1};
            state <= S_OUT;
          end else begin
            t_wdata <= '{size: req, next: IW'(sp_rd), prev: cb.prev, used: 1'b1};
            granted_bytes <= 15'(req);
            state <= S_SPLIT_NRD;
          end
        end
        S_SPLIT_NRD: begin
          t_waddr <= sp_rd;
          t_wdata <= '{size: cb.size - need, next: cb.next, prev: pick, used: 1'b0};
          if (cb.next < NONE) begin
            t_raddr <= cb.next[AW-1:0];
            state <= S_SPLIT_NRDW;
          end else begin
            state <= S_OUT;
          end
        end
        S_SPLIT_NRDW: state <= S_SPLIT_NW;
        S_SPLIT_NW: begin
          t_waddr <= cb.next[AW-1:0];
          t_wdata <= '{size: t_r.size, next: t_r.next, prev: IW'(sp_rd), used: t_r.used};
          state <= S_OUT;
        end
        // Free: cb holds the freed block, now check the previous one.
        S_FR_P: begin
          cb.used <= 1'b0;
          if (cb.prev < NONE) begin
            t_raddr <= cb.prev[AW-1:0];
            state <= S_FR_RD;
          end else begin
            state <= S_FR_N;
          end
        end
        S_FR_RD: state <= S_FR_RDW;
        S_FR_RDW: begin
          if (!t_r.used) begin
            // Absorb the freed block into its predecessor; recycle its entry.
            tmp_n <= cur;
            cb <= '{size: t_r.size + HDR + cb.size, next: cb.next, prev: t_r.prev,
                    used: 1'b0};
            cur <= cb.prev;
            state <= S_FR_PW;
          end else begin
            state <= S_FR_N;
          end
        end
        S_FR_PW: begin
          if (sp_cnt < NONE) sp_cnt <= sp_cnt + 1'b1;
          state <= S_FR_N;
        end
        S_FR_N: begin
          if (cb.next < NONE) begin
            t_raddr <= cb.next[AW-1:0];
            state <= S_FR_NW;
          end else begin
            state <= S_FR_CUR;
          end
        end
        S_FR_NW: state <= S_FR_NN;
        S_FR_NN: begin
          if (!t_r.used) begin
            // Absorb the successor; its entry goes back on the spare stack.
            tmp_n <= cb.next;
            cb <= '{size: cb.size + HDR + t_r.size, next: t_r.next, prev: cb.prev,
                    used: 1'b0};
            state <= S_FR_NNW;
          end else begin
            // The successor stays; its back link is rewritten when it changed.
            t_waddr <= cb.next[AW-1:0];
            t_wdata <= '{size: t_r.size, next: t_r.next, prev: cur, used: t_r.used};
            state <= S_FR_CUR;
          end
        end
        S_FR_NNW: begin
          if (sp_cnt < NONE) sp_cnt <= sp_cnt + 1'b1;
          if (cb.next < NONE) begin
            t_raddr <= cb.next[AW-1:0];
            state <= S_FR_SW;
          end else begin
            state <= S_FR_CUR;
          end
        end
        S_FR_SW: state <= S_FR_SX;
        S_FR_SX: begin
          t_waddr <= cb.next[AW-1:0];
          t_wdata <= '{size: t_r.size, next: t_r.next, prev: cur, used: t_r.used};
          state <= S_FR_CUR;
        end
        S_FR_CUR: begin
          t_waddr <= cur[AW-1:0];
          t_wdata <= cb;
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/bfa_checker.sv
module bfa_props (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        opcode,
  input logic [14:0] request_size,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [13:0] data_offset,
  input logic [14:0] granted_bytes
);
  import bfa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_offset))
    else $error("result word changed while stalled");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> data_offset == '0 && granted_bytes == '0)
    else $error("failed request carries an offset");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("new word taken while a result waits");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_ALLOC && request_size == '0 |=>
    out_valid && status == ST_BAD_SIZE)
    else $error("zero size not rejected");
endmodule

bind best_fit_block_allocator bfa_props u_bfa_props (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
  .request_size(request_size), .out_valid(out_valid), .out_ready(out_ready),
  .status(status), .data_offset(data_offset), .granted_bytes(granted_bytes)
);
